>>> src/cphl_pkg.sv
// shared types, constants and helpers of the capsule distance huber loss block
package cphl_pkg;

    localparam int COORD_W     = 32;
    localparam int DIFF_W      = 33;
    localparam int ACC_W       = 66;
    localparam int T_W         = 48;
    localparam int T_HALF_W    = 24;
    localparam int VEC_W       = 35;
    localparam int MAG_W       = 34;
    localparam int SQ_W        = 68;
    localparam int ROOT_W      = 34;
    localparam int SREM_W      = 36;
    localparam int DIST_W      = 32;
    localparam int LOSS_W      = 64;
    localparam int RAD_W       = 31;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam logic [ACC_W-1:0] AXIS_SQ_MAX = ACC_W'(4);

    typedef enum logic [1:0] {
        REGION_CAP_A  = 2'd0,
        REGION_SHAFT  = 2'd1,
        REGION_CAP_B  = 2'd2,
        REGION_SPHERE = 2'd3
    } region_t;

    typedef enum logic [2:0] {
        CFG_END_A_X    = 3'd0,
        CFG_END_A_Y    = 3'd1,
        CFG_END_A_Z    = 3'd2,
        CFG_END_B_X    = 3'd3,
        CFG_END_B_Y    = 3'd4,
        CFG_END_B_Z    = 3'd5,
        CFG_CAP_RADIUS = 3'd6,
        CFG_HUBER_W    = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_OFF,
        B_SQ,
        B_SQRT,
        B_DIST,
        B_HUB,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
        logic                      last_vertex;
    } in_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] surface_distance;
        logic [1:0]        region;
        logic [LOSS_W-1:0] point_loss;
        logic [LOSS_W-1:0] total_loss;
        logic              last_out;
    } out_item_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] end_a;
        logic [2:0][COORD_W-1:0] end_b;
        logic [RAD_W-1:0]        cap_radius;
        logic [RAD_W-1:0]        huber_width;
    } geom_t;

    // one classified vertex handed from front to back
    typedef struct packed {
        logic [2:0][DIFF_W-1:0] u;
        logic [2:0][DIFF_W-1:0] v;
        logic [2:0][DIFF_W-1:0] w;
        logic [ACC_W-1:0]       dot;
        logic [ACC_W-1:0]       len2;
        region_t                region;
        logic                   last;
    } job_t;

    function automatic logic [DIFF_W-1:0] mag_diff(input logic [DIFF_W-1:0] x);
        return x[DIFF_W-1] ? (~x + DIFF_W'(1)) : x;
    endfunction

    function automatic logic [MAG_W-1:0] mag_vec(input logic [VEC_W-1:0] x);
        logic [VEC_W-1:0] m;
        m = x[VEC_W-1] ? (~x + VEC_W'(1)) : x;
        return m[MAG_W-1:0];
    endfunction

endpackage

>>> src/capsule_point_huber_loss.sv
// top level of the point to capsule distance huber loss block
// Each vertex beat (Q16.16 x/y/z plus a last flag) yields one result beat with
// the distance to the capsule surface, the region used (cap A, shaft, cap B or
// sphere for a near zero axis), the huber loss of that distance in Q32.32 and
// the running loss sum, which the last-flagged vertex reports and then clears.
// The front end takes a vertex and forms the axis length and dot product on
// its own multiplier; a short queue then hands it to the back end, which is
// the pace setter through the 48-step projection divider, run only for a
// shaft vertex, and the 34-step square root; neither uses the back end's
// single multiplier. A finished result waits in the output register while
// the next vertex is already being worked on. Configuration writes are always
// ready and must only be issued while no vertex is in flight.
module capsule_point_huber_loss
    import cphl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // vertex side
    input  logic                push,
    output logic                full,
    input  in_item_t            in_item,
    // result side
    output logic                empty,
    input  logic                pop,
    output out_item_t           out_item,
    // configuration
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [COORD_W-1:0]  cfg_data
);

    geom_t geom_reg;
    job_t  front_job, back_job;
    logic  front_valid, queue_ready, queue_valid, back_take;

    assign cfg_ready = 1'b1;

    // capsule registers, endpoint B starts one unit up the y axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.end_a       <= '0;
            geom_reg.end_b       <= {32'd0, 32'd65536, 32'd0};
            geom_reg.cap_radius  <= RAD_W'(65536);
            geom_reg.huber_width <= RAD_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_END_A_X:    geom_reg.end_a[0]    <= cfg_data;
                CFG_END_A_Y:    geom_reg.end_a[1]    <= cfg_data;
                CFG_END_A_Z:    geom_reg.end_a[2]    <= cfg_data;
                CFG_END_B_X:    geom_reg.end_b[0]    <= cfg_data;
                CFG_END_B_Y:    geom_reg.end_b[1]    <= cfg_data;
                CFG_END_B_Z:    geom_reg.end_b[2]    <= cfg_data;
                CFG_CAP_RADIUS: geom_reg.cap_radius  <= cfg_data[RAD_W-1:0];
                CFG_HUBER_W:    geom_reg.huber_width <= cfg_data[RAD_W-1:0];
                default:        geom_reg.end_a       <= geom_reg.end_a;
            endcase
        end
    end

    // classify each vertex beat
    cphl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .geom      (geom_reg),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (queue_ready)
    );

    // decouple the two halves
    cphl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (front_job),
        .wr_valid (front_valid),
        .wr_ready (queue_ready),
        .rd_data  (back_job),
        .rd_valid (queue_valid),
        .rd_take  (back_take)
    );

    // distance, loss and running sum
    cphl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_valid (queue_valid),
        .job_take  (back_take),
        .geom      (geom_reg),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

endmodule

>>> src/cphl_front.sv
// front end: takes a vertex beat, forms axis length and dot product, classifies
module cphl_front
    import cphl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t in_item,
    input  geom_t    geom,
    output job_t     job,
    output logic     job_valid,
    input  logic     job_ready
);

    front_state_t state_reg, state_next;
    logic [2:0]   cnt_reg;
    logic [2:0][DIFF_W-1:0] u_reg, v_reg, w_reg;
    logic         last_reg;
    logic [ACC_W-1:0] prod_reg, len_reg, pos_reg, neg_reg;
    logic [DIFF_W-1:0] op_a, op_b;
    logic [2:0]   step;
    logic [1:0]   j;
    logic [2:0][DIFF_W-1:0] u_in, v_in, w_in;
    logic [COORD_W-1:0] p_in [3];
    logic         take;

    assign p_in[0] = in_item.vertex_x;
    assign p_in[1] = in_item.vertex_y;
    assign p_in[2] = in_item.vertex_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_in[i] = {p_in[i][COORD_W-1], p_in[i]}
                    - {geom.end_a[i][COORD_W-1], geom.end_a[i]};
            v_in[i] = {geom.end_b[i][COORD_W-1], geom.end_b[i]}
                    - {geom.end_a[i][COORD_W-1], geom.end_a[i]};
            w_in[i] = {p_in[i][COORD_W-1], p_in[i]}
                    - {geom.end_b[i][COORD_W-1], geom.end_b[i]};
        end
    end

    assign take = (state_reg == F_IDLE) && push;
    assign step = cnt_reg - 3'd1;

    // steps 0..2 square the axis, steps 3..5 form |u_i||v_i|
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cnt_reg)
            3'd0, 3'd1, 3'd2:
            begin
                op_a = mag_diff(v_reg[cnt_reg[1:0]]);
                op_b = mag_diff(v_reg[cnt_reg[1:0]]);
            end
            3'd3, 3'd4, 3'd5:
            begin
                op_a = mag_diff(u_reg[2'(cnt_reg - 3'd3)]);
                op_b = mag_diff(v_reg[2'(cnt_reg - 3'd3)]);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign j = 2'(step - 3'd3);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (push) state_next = F_MUL;
            F_MUL:   if (cnt_reg == 3'd6) state_next = F_PUSH;
            F_PUSH:  if (job_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        full      = (state_reg != F_IDLE);
        job_valid = (state_reg == F_PUSH);
    end

    // classification
    always_comb
    begin
        job.u    = u_reg;
        job.v    = v_reg;
        job.w    = w_reg;
        job.len2 = len_reg;
        job.dot  = pos_reg - neg_reg;
        job.last = last_reg;
        if (len_reg <= AXIS_SQ_MAX)
            job.region = REGION_SPHERE;
        else if (pos_reg <= neg_reg)
            job.region = REGION_CAP_A;
        else if ((pos_reg - neg_reg) >= len_reg)
            job.region = REGION_CAP_B;
        else
            job.region = REGION_SHAFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
                cnt_reg <= '0;
            else if (state_reg == F_MUL)
                cnt_reg <= cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ACC_W'(op_a * op_b);
        if (take)
        begin
            u_reg    <= u_in;
            v_reg    <= v_in;
            w_reg    <= w_in;
            last_reg <= in_item.last_vertex;
            len_reg  <= '0;
            pos_reg  <= '0;
            neg_reg  <= '0;
        end
        else if (state_reg == F_MUL && cnt_reg != 3'd0)
        begin
            if (step < 3'd3)
                len_reg <= len_reg + prod_reg;
            else if (u_reg[j][DIFF_W-1] != v_reg[j][DIFF_W-1])
                neg_reg <= neg_reg + prod_reg;
            else
                pos_reg <= pos_reg + prod_reg;
        end
    end

endmodule

>>> src/cphl_queue.sv
// short job queue between front and back end
module cphl_queue
    import cphl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  job_t wr_data,
    input  logic wr_valid,
    output logic wr_ready,
    output job_t rd_data,
    output logic rd_valid,
    input  logic rd_take
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_take && rd_valid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr) wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (do_rd) rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> src/cphl_back.sv
// back end: projection divide, offsets, square root, huber loss and running sum
module cphl_back
    import cphl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      job,
    input  logic      job_valid,
    output logic      job_take,
    input  geom_t     geom,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    back_state_t st_reg, st_next;
    logic [5:0]  cnt_reg;
    logic [2:0][DIFF_W-1:0] u_reg, v_reg;
    logic [2:0][VEC_W-1:0]  vec_reg;
    logic [ACC_W-1:0]  len_reg, rem_reg;
    logic [T_W-1:0]    quo_reg;
    logic [56:0]       lo_reg;
    logic [SQ_W-1:0]   sq_reg, prod_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SREM_W-1:0] srem_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [LOSS_W-1:0] p1_reg, loss_reg, sum_reg;
    region_t           region_reg;
    logic              last_reg;
    out_item_t         out_reg;
    logic              out_full_reg;

    logic [MAG_W-1:0]  mul_a, mul_b;
    logic [ACC_W:0]    div_sh;
    logic              div_ge;
    logic [2:0]        step;
    logic [1:0]        oi;
    logic [81:0]       off_full;
    logic [MAG_W-1:0]  off;
    logic [VEC_W-1:0]  u_ext;
    logic [SREM_W+1:0] rt_rem, rt_trial;
    logic              rt_ge;
    logic [ROOT_W:0]   d_val, r_val, s_full;
    logic [RAD_W-1:0]  hw;
    logic              quad;
    logic [LOSS_W:0]   sum_full;
    logic [LOSS_W-1:0] sum_new;
    logic              out_free, load, done_fire, last_cnt;

    assign out_free  = !out_full_reg || pop;
    assign load      = (st_reg == B_IDLE) && job_valid;
    assign done_fire = (st_reg == B_DONE) && out_free;
    assign step      = 3'(cnt_reg - 6'd1);
    assign oi        = step[2:1];
    assign hw        = geom.huber_width;
    assign quad      = ({1'b0, dist_reg} <= {2'b0, hw});

    always_comb
    begin
        case (st_reg)
            B_DIV:   last_cnt = (cnt_reg == 6'(T_W - 1));
            B_OFF:   last_cnt = (cnt_reg == 6'd6);
            B_SQ:    last_cnt = (cnt_reg == 6'd3);
            B_SQRT:  last_cnt = (cnt_reg == 6'(ROOT_W - 1));
            B_HUB:   last_cnt = (cnt_reg == 6'd2);
            default: last_cnt = 1'b0;
        endcase
    end

    // restoring division, one quotient bit per cycle
    assign div_sh = {rem_reg, 1'b0};
    assign div_ge = div_sh >= {1'b0, len_reg};

    // offset of one axis component, rounded half up
    assign off_full = {prod_reg[56:0], 24'b0} + {25'b0, lo_reg} + (82'd1 << (T_W - 1));
    assign off      = off_full[81:T_W];
    assign u_ext    = {{2{u_reg[oi][DIFF_W-1]}}, u_reg[oi]};

    // square root, two radicand bits per cycle
    assign rt_rem   = {srem_reg, sq_reg[SQ_W-1:SQ_W-2]};
    assign rt_trial = {2'b0, root_reg, 2'b01};
    assign rt_ge    = rt_rem >= rt_trial;

    always_comb
    begin
        d_val = {1'b0, root_reg} + {{ROOT_W{1'b0}}, ({2'b0, root_reg} < srem_reg)};
        r_val = (geom.cap_radius == '0) ? (ROOT_W+1)'(1) : (ROOT_W+1)'(geom.cap_radius);
        s_full = (d_val >= r_val) ? d_val - r_val : r_val - d_val;
    end

    assign sum_full = {1'b0, sum_reg} + {1'b0, loss_reg};
    assign sum_new  = sum_full[LOSS_W] ? '1 : sum_full[LOSS_W-1:0];

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (st_reg)
            B_OFF:
            begin
                mul_a = cnt_reg[0] ? MAG_W'(quo_reg[T_W-1:T_HALF_W])
                                   : MAG_W'(quo_reg[T_HALF_W-1:0]);
                mul_b = MAG_W'(mag_diff(v_reg[cnt_reg[2:1]]));
            end
            B_SQ:
            begin
                mul_a = mag_vec(vec_reg[cnt_reg[1:0]]);
                mul_b = mag_vec(vec_reg[cnt_reg[1:0]]);
            end
            B_HUB:
            begin
                if (cnt_reg == 6'd0)
                begin
                    mul_a = quad ? MAG_W'(dist_reg) : MAG_W'(hw);
                    mul_b = MAG_W'(dist_reg);
                end
                else
                begin
                    mul_a = MAG_W'(hw);
                    mul_b = MAG_W'(hw);
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            B_IDLE:  if (job_valid) st_next = (job.region == REGION_SHAFT) ? B_DIV : B_SQ;
            B_DIV:   if (last_cnt) st_next = B_OFF;
            B_OFF:   if (last_cnt) st_next = B_SQ;
            B_SQ:    if (last_cnt) st_next = B_SQRT;
            B_SQRT:  if (last_cnt) st_next = B_DIST;
            B_DIST:  st_next = B_HUB;
            B_HUB:   if (last_cnt) st_next = B_DONE;
            B_DONE:  if (out_free) st_next = B_IDLE;
            default: st_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        job_take = load;
        empty    = !out_full_reg;
        out_item = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= B_IDLE;
            cnt_reg      <= '0;
            out_full_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_next != st_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 6'd1;
            if (done_fire)
            begin
                out_full_reg <= 1'b1;
                sum_reg      <= last_reg ? '0 : sum_new;
            end
            else if (pop)
                out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= SQ_W'(mul_a * mul_b);
        case (st_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    u_reg      <= job.u;
                    v_reg      <= job.v;
                    len_reg    <= job.len2;
                    rem_reg    <= job.dot;
                    region_reg <= job.region;
                    last_reg   <= job.last;
                    sq_reg     <= '0;
                    for (int i = 0; i < 3; i++)
                        vec_reg[i] <= (job.region == REGION_CAP_B)
                            ? {{2{job.w[i][DIFF_W-1]}}, job.w[i]}
                            : {{2{job.u[i][DIFF_W-1]}}, job.u[i]};
                end
            end
            B_DIV:
            begin
                rem_reg <= div_ge ? ACC_W'(div_sh - {1'b0, len_reg}) : div_sh[ACC_W-1:0];
                quo_reg <= {quo_reg[T_W-2:0], div_ge};
            end
            B_OFF:
            begin
                if (cnt_reg != 6'd0)
                begin
                    if (!step[0])
                        lo_reg <= prod_reg[56:0];
                    else if (v_reg[oi][DIFF_W-1])
                        vec_reg[oi] <= u_ext + {1'b0, off};
                    else
                        vec_reg[oi] <= u_ext - {1'b0, off};
                end
            end
            B_SQ:
            begin
                if (cnt_reg != 6'd0)
                    sq_reg <= sq_reg + prod_reg;
                root_reg <= '0;
                srem_reg <= '0;
            end
            B_SQRT:
            begin
                srem_reg <= rt_ge ? SREM_W'(rt_rem - rt_trial) : rt_rem[SREM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], rt_ge};
                sq_reg   <= {sq_reg[SQ_W-3:0], 2'b00};
            end
            B_DIST:
                dist_reg <= (s_full[ROOT_W:DIST_W] != '0) ? '1 : s_full[DIST_W-1:0];
            B_HUB:
            begin
                if (cnt_reg == 6'd1)
                    p1_reg <= prod_reg[LOSS_W-1:0];
                else if (cnt_reg == 6'd2)
                    loss_reg <= quad ? {1'b0, p1_reg[LOSS_W-1:1]}
                                     : LOSS_W'(({p1_reg, 1'b0} - {1'b0, prod_reg[LOSS_W-1:0]}) >> 1);
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    out_reg.surface_distance <= dist_reg;
                    out_reg.region           <= region_reg;
                    out_reg.point_loss       <= loss_reg;
                    out_reg.total_loss       <= sum_new;
                    out_reg.last_out         <= last_reg;
                end
            end
            default:
            begin
                lo_reg <= lo_reg;
            end
        endcase
    end

endmodule

>>> src/cphl_checker.sv
// port level checks of the capsule huber loss block and their bind
module cphl_checker
    import cphl_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input out_item_t out_item
);

    logic fresh_reg;

    // the next result after reset or after a last beat starts a new sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fresh_reg <= 1'b1;
        else if (pop && !empty)
            fresh_reg <= out_item.last_out;
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_item))
        else $error("result beat changed while waiting");

    a_sum_covers_point: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> out_item.total_loss >= out_item.point_loss)
        else $error("running sum below point loss");

    a_sum_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && fresh_reg |-> out_item.total_loss == out_item.point_loss)
        else $error("sum not cleared after last vertex");

    a_zero_width_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_item.point_loss == '0 && !fresh_reg
            |-> out_item.total_loss >= out_item.point_loss)
        else $error("sum inconsistent with zero loss");

endmodule

bind capsule_point_huber_loss cphl_checker u_cphl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);

>>> sim/tb_top.sv
// testbench for the capsule distance huber loss block: directed and random vertex clouds
`timescale 1ns / 1ps

module tb_top
    import cphl_pkg::*;
();

    // scoreboard: holds the capsule settings, the running loss sum and the results owed
    class loss_board;
        logic signed [31:0] pa[3];
        logic signed [31:0] pb[3];
        logic [30:0]        radius;
        logic [30:0]        hwidth;
        logic [63:0]        run_sum;
        out_item_t          owed[$];
        int                 errors;
        int                 checked;
        int                 region_seen[4];

        function new();
            foreach (pa[i]) pa[i] = '0;
            foreach (pb[i]) pb[i] = '0;
            pb[1] = 32'sd65536;
            radius = 31'd65536;
            hwidth = 31'd65536;
            run_sum = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [31:0] val);
            case (idx)
                CFG_END_A_X:    pa[0] = val;
                CFG_END_A_Y:    pa[1] = val;
                CFG_END_A_Z:    pa[2] = val;
                CFG_END_B_X:    pb[0] = val;
                CFG_END_B_Y:    pb[1] = val;
                CFG_END_B_Z:    pb[2] = val;
                CFG_CAP_RADIUS: radius = val[30:0];
                default:        hwidth = val[30:0];
            endcase
        endfunction

        // rounded square root, ties up
        function logic [63:0] root_near(logic [127:0] s);
            logic [63:0]  r;
            logic [63:0]  c;
            logic [127:0] rem;
            r = '0;
            for (int b = 63; b >= 0; b--)
            begin
                c = r | (64'd1 << b);
                if (128'(c) * 128'(c) <= s) r = c;
            end
            rem = s - 128'(r) * 128'(r);
            if (rem > 128'(r)) r = r + 1;
            return r;
        endfunction

        function logic [127:0] norm_sq(logic signed [34:0] x[3]);
            logic [127:0] acc;
            logic [63:0]  m;
            acc = '0;
            for (int i = 0; i < 3; i++)
            begin
                m = x[i] < 0 ? 64'(-x[i]) : 64'(x[i]);
                acc += 128'(m) * 128'(m);
            end
            return acc;
        endfunction

        // work out the result owed for one accepted vertex
        function void note_vertex(in_item_t it);
            logic signed [34:0]  u[3], v[3], w[3], n[3];
            logic signed [127:0] dotp;
            logic [127:0]        len2, prod;
            logic [63:0]         t, dist_q, s, r, wd, loss, off, vm;
            logic [1:0]          reg_q;
            out_item_t           res;
            logic signed [31:0]  p[3];
            p[0] = it.vertex_x;
            p[1] = it.vertex_y;
            p[2] = it.vertex_z;
            dotp = '0;
            for (int i = 0; i < 3; i++)
            begin
                u[i] = 35'(p[i]) - 35'(pa[i]);
                v[i] = 35'(pb[i]) - 35'(pa[i]);
                w[i] = 35'(p[i]) - 35'(pb[i]);
                dotp += 128'(u[i]) * 128'(v[i]);
            end
            len2 = norm_sq(v);
            if (len2 <= 128'd4)
            begin
                reg_q = REGION_SPHERE;
                dist_q = root_near(norm_sq(u));
            end
            else if (dotp <= 0)
            begin
                reg_q = REGION_CAP_A;
                dist_q = root_near(norm_sq(u));
            end
            else if (128'(dotp) >= len2)
            begin
                reg_q = REGION_CAP_B;
                dist_q = root_near(norm_sq(w));
            end
            else
            begin
                reg_q = REGION_SHAFT;
                t = 64'((128'(dotp) << 48) / len2);
                for (int i = 0; i < 3; i++)
                begin
                    vm = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
                    prod = 128'(t) * 128'(vm) + (128'd1 << 47);
                    off = 64'(prod >> 48);
                    n[i] = v[i] < 0 ? u[i] + 35'(off) : u[i] - 35'(off);
                end
                dist_q = root_near(norm_sq(n));
            end
            r = radius == 0 ? 64'd1 : 64'(radius);
            s = dist_q >= r ? dist_q - r : r - dist_q;
            if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
            wd = 64'(hwidth);
            if (s <= wd) loss = (s * s) >> 1;
            else loss = (2 * wd * s - wd * wd) >> 1;
            run_sum = (run_sum + loss < run_sum) ? '1 : run_sum + loss;
            res.surface_distance = s[31:0];
            res.region = reg_q;
            res.point_loss = loss;
            res.total_loss = run_sum;
            res.last_out = it.last_vertex;
            if (it.last_vertex) run_sum = '0;
            owed = {owed, res};
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            checked++;
            if (owed.size() == 0)
            begin
                $display("%0t unexpected result beat %p", $time, got);
                errors++;
                return;
            end
            exp = owed.pop_front();
            region_seen[exp.region]++;
            if (got.surface_distance !== exp.surface_distance)
            begin
                $display("%0t surface_distance exp %h got %h", $time,
                         exp.surface_distance, got.surface_distance);
                errors++;
            end
            if (got.region !== exp.region)
            begin
                $display("%0t region exp %0d got %0d", $time, exp.region, got.region);
                errors++;
            end
            if (got.point_loss !== exp.point_loss)
            begin
                $display("%0t point_loss exp %h got %h", $time, exp.point_loss, got.point_loss);
                errors++;
            end
            if (got.total_loss !== exp.total_loss)
            begin
                $display("%0t total_loss exp %h got %h", $time, exp.total_loss, got.total_loss);
                errors++;
            end
            if (got.last_out !== exp.last_out)
            begin
                $display("%0t last_out exp %b got %b", $time, exp.last_out, got.last_out);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    in_item_t    in_item;
    logic        empty;
    logic        pop;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    loss_board board;
    bit        calm;       // no idling on either side while set
    bit        stim_done;
    int        sent;

    capsule_point_huber_loss u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: pop at random, check every accepted beat at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty) board.check_result(out_item);
            pop <= calm ? 1'b1 : ($urandom_range(99) >= 20);
        end
        else
            pop <= 1'b0;
    end

    // one register write on the config channel
    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_reg(idx, val);
    endtask

    // wait until every owed result is back, then let the back end drain
    task automatic drain();
        push <= 1'b0;
        while (board.owed.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // one vertex beat, with a random gap ahead of it
    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic last);
        in_item_t it;
        it.vertex_x = x;
        it.vertex_y = y;
        it.vertex_z = z;
        it.last_vertex = last;
        if (!calm)
            while ($urandom_range(99) < 20)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        push    <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        board.note_vertex(it);
        sent++;
    endtask

    task automatic set_capsule(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                               logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                               logic [31:0] rad, logic [31:0] hw);
        write_reg(CFG_END_A_X, ax);
        write_reg(CFG_END_A_Y, ay);
        write_reg(CFG_END_A_Z, az);
        write_reg(CFG_END_B_X, bx);
        write_reg(CFG_END_B_Y, by);
        write_reg(CFG_END_B_Z, bz);
        write_reg(CFG_CAP_RADIUS, rad);
        write_reg(CFG_HUBER_W, hw);
        cfg_valid <= 1'b0;
    endtask

    // coordinate mostly near the capsule, sometimes anywhere
    function automatic logic [31:0] near_coord(logic [31:0] base);
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return base + ($urandom_range(8) - 4);
            default: return base + ($urandom_range(32'h6_0000) - 32'h3_0000);
        endcase
    endfunction

    task automatic random_cloud(int count);
        logic [31:0] bx[3];
        for (int k = 0; k < count; k++)
        begin
            bx[0] = $urandom_range(1) ? board.pa[0] : board.pb[0];
            bx[1] = $urandom_range(1) ? board.pa[1] : board.pb[1];
            bx[2] = $urandom_range(1) ? board.pa[2] : board.pb[2];
            send_vertex(near_coord(bx[0]), near_coord(bx[1]), near_coord(bx[2]),
                        $urandom_range(15) == 0);
        end
        send_vertex($urandom, $urandom, $urandom, 1'b1);
    endtask

    initial
    begin
        logic [31:0] s;
        board = new();
        calm = 1'b0;
        stim_done = 1'b0;
        sent = 0;
        push = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset capsule (unit shaft along y)
        send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b0);            // on the axis at A
        send_vertex(32'sd65536, 32'sd32768, 32'sd0, 1'b0);    // shaft
        send_vertex(32'sd0, -32'sd131072, 32'sd0, 1'b0);      // before A
        send_vertex(32'sd0, 32'sd300000, 32'sd5, 1'b0);       // beyond B
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        drain();

        // extremes of geometry, zero radius and zero huber width
        set_capsule(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0);
        send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'sd0, 1'b0);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        drain();
        // degenerate axis of one raw step and max radius and width
        set_capsule(32'sd100, 32'sd0, 32'sd0, 32'sd101, 32'sd1, 32'sd0,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_vertex(32'sd100, 32'sd0, 32'sd0, 1'b1);
        drain();
        // sum saturation: huge distances with a wide huber width
        set_capsule(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF);
        for (int k = 0; k < 6; k++)
            send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, k == 5);
        // index beyond the list cannot be formed on a 3-bit channel
        drain();

        // random phases with fresh capsules; one phase without idling
        for (int ph = 0; ph < 12; ph++)
        begin
            calm = (ph == 5);
            s = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h4_0000);
            if ($urandom_range(4) == 0)
                set_capsule(s, s, s, s + $urandom_range(2), s, s,
                            $urandom_range(32'h2_0000), $urandom_range(32'h2_0000));
            else
                set_capsule($urandom, near_coord(s), s, near_coord(s), $urandom, s,
                            $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h4_0000),
                            $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h4_0000));
            random_cloud(140);
            drain();
        end
        calm = 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        $display("vertices sent %0d, results checked %0d", sent, board.checked);
        $display("regions cap a %0d shaft %0d cap b %0d sphere %0d",
                 board.region_seen[0], board.region_seen[1],
                 board.region_seen[2], board.region_seen[3]);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("timeout, %0d results still owed", board.owed.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule
